### hw/rtl/grc_pkg.sv
`timescale 1ns / 1ps
package grc_pkg;

    localparam int MaxGridSideDef = 256;
    localparam int AngleBitsDef   = 12;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] CFG_ORIGIN_X        = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_ORIGIN_Y        = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_CELL_SIZE       = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_CELLS_PER_METER = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_GRID_WIDTH      = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_GRID_HEIGHT     = 3'd5;

    localparam logic [20:0] CellSizeRst      = 21'd3277;
    localparam logic [22:0] CellsPerMeterRst = 23'd1310720;
    localparam logic [8:0]  GridSideRst      = 9'd256;

    localparam logic signed [7:0] OccThresh = 8'sd50;

    localparam int TrigW = 15;
    localparam int MulW  = 24;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_CAST = 1'b1;

    function automatic int qcos(int i, int ang_bits);
        real a;
        begin
            a = 3.14159265358979323846 * i * (2.0 ** (1 - ang_bits));
            return $rtoi(32767.0 * $cos(a) + 0.5);
        end
    endfunction

endpackage

### hw/rtl/grc_mul.sv
`timescale 1ns / 1ps
module grc_mul (
    input  logic                       i_clk,
    input  logic [grc_pkg::MulW-1:0]   i_a,
    input  logic [grc_pkg::MulW-1:0]   i_b,
    output logic [2*grc_pkg::MulW-1:0] o_p
);
    import grc_pkg::*;

    logic [2*MulW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= (2*MulW)'(i_a) * (2*MulW)'(i_b);
    end

    assign o_p = r_p;
endmodule

### hw/rtl/grc_cos_rom.sv
`timescale 1ns / 1ps
module grc_cos_rom #(
    parameter int AngleBits = grc_pkg::AngleBitsDef
) (
    input  logic                      i_clk,
    input  logic [AngleBits-2:0]      i_addr,
    output logic [grc_pkg::TrigW-1:0] o_data
);
    import grc_pkg::*;

    localparam int Quarter = 1 << (AngleBits - 2);

    logic [TrigW-1:0] w_tab [0:Quarter];
    logic [TrigW-1:0] r_data;

    for (genvar g = 0; g <= Quarter; g++) begin : g_tab
        assign w_tab[g] = TrigW'(qcos(g, AngleBits));
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_tab[i_addr];
    end

    assign o_data = r_data;
endmodule

### hw/rtl/grc_occ_mem.sv
`timescale 1ns / 1ps
module grc_occ_mem #(
    parameter int AddrW = 16
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic             i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output logic             o_rdata
);
    logic r_mem [0:(1<<AddrW)-1];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/grid_ray_cast_range_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Ports
// request   in/out     start (in), busy (out), i_req_type, i_cell_index, i_cell_value,
//                      i_pose_x, i_pose_y, i_pose_heading, i_beam_angle, i_max_range
// result    out        o_result_valid, o_range, o_hit_found
// config    in         i_cfg_wr_en, i_cfg_index, i_cfg_wdata
//
// A load request returns nothing; busy stays low.
// A cast request runs setup states TC to DW, then half-cell steps through states CHK to
// RD until a hit, a grid edge or the closing range check ends it; the step time is set
// by the shared 24x24 multiplier, which serves both coordinates and the cell index, and
// the grid read. The final result is shown in the cycle after the last step decision.
// Reset is synchronous and active low; the occupancy store is not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
module grid_ray_cast_range_unit #(
    parameter int MaxGridSide = grc_pkg::MaxGridSideDef,
    parameter int AngleBits   = grc_pkg::AngleBitsDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_req_type,
    input  logic [15:0]                  i_cell_index,
    input  logic signed [7:0]            i_cell_value,
    input  logic signed [31:0]           i_pose_x,
    input  logic signed [31:0]           i_pose_y,
    input  logic [11:0]                  i_pose_heading,
    input  logic [11:0]                  i_beam_angle,
    input  logic [23:0]                  i_max_range,
    input  logic                         i_cfg_wr_en,
    input  logic [grc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [grc_pkg::CfgDataW-1:0] i_cfg_wdata,
    output logic                         o_result_valid,
    output logic [23:0]                  o_range,
    output logic                         o_hit_found
);
    import grc_pkg::*;

    localparam int AddrW   = 2 * $clog2(MaxGridSide);
    localparam int Cells   = MaxGridSide * MaxGridSide;
    localparam int Quarter = 1 << (AngleBits - 2);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_TC   = 5'd1;
    localparam logic [4:0] S_TS   = 5'd2;
    localparam logic [4:0] S_DX   = 5'd3;
    localparam logic [4:0] S_DY   = 5'd4;
    localparam logic [4:0] S_DW   = 5'd5;
    localparam logic [4:0] S_CHK  = 5'd6;
    localparam logic [4:0] S_XL   = 5'd7;
    localparam logic [4:0] S_XH   = 5'd8;
    localparam logic [4:0] S_XF   = 5'd9;
    localparam logic [4:0] S_YL   = 5'd10;
    localparam logic [4:0] S_YH   = 5'd11;
    localparam logic [4:0] S_YF   = 5'd12;
    localparam logic [4:0] S_BND  = 5'd13;
    localparam logic [4:0] S_IDX  = 5'd14;
    localparam logic [4:0] S_RD   = 5'd15;

    logic [4:0]  r_state, n_state;

    logic signed [31:0] r_origin_x, r_origin_y;
    logic [20:0] r_cell_size;
    logic [22:0] r_cpm;
    logic [8:0]  r_gw, r_gh;

    logic signed [31:0] r_sx, r_sy;
    logic [AngleBits-1:0] r_ang;
    logic [23:0] r_max;
    logic [24:0] r_range;
    logic [TrigW-1:0] r_cmag;
    logic r_cneg, r_sneg;
    logic signed [35:0] r_dx, r_dy;
    logic signed [41:0] r_accx, r_accy;
    logic [34:0] r_mag;
    logic r_neg, r_negx, r_negy;
    logic [47:0] r_plo;
    logic [25:0] r_cx, r_cy;
    logic r_valid, r_hit;
    logic [23:0] r_out_range;

    logic [MulW-1:0]   w_mul_a, w_mul_b;
    logic [2*MulW-1:0] w_p;
    logic [AngleBits-2:0] w_rom_addr;
    logic [TrigW-1:0] w_rom;
    logic w_occ;
    logic [AddrW-1:0] w_raddr;
    logic w_load;

    logic [19:0] w_step;
    logic [12:0] w_ang_sum;
    logic [AngleBits-1:0] w_sang;
    logic [1:0] w_quad;
    logic [AngleBits-3:0] w_rem;
    logic w_qneg;
    logic signed [34:0] w_rel;
    logic [57:0] w_cell_prod;
    logic w_out;
    logic [18:0] w_idx;
    logic [35:0] w_dmag;

    grc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_p)
    );

    grc_cos_rom #(.AngleBits(AngleBits)) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom)
    );

    assign w_load = start && !busy && (i_req_type == REQ_LOAD)
                    && (32'(i_cell_index) < 32'(Cells));

    grc_occ_mem #(.AddrW(AddrW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (AddrW'(i_cell_index)),
        .i_wdata (i_cell_value > OccThresh),
        .i_raddr (w_raddr),
        .o_rdata (w_occ)
    );

    assign busy = (r_state != S_IDLE);
    assign w_step = (r_cell_size[20:1] == 20'd0) ? 20'd1 : r_cell_size[20:1];
    assign w_ang_sum = 13'(i_pose_heading) + 13'(i_beam_angle);
    assign w_sang = r_ang - AngleBits'(Quarter);

    always_comb begin
        if (r_state == S_TC) begin
            w_quad = r_ang[AngleBits-1:AngleBits-2];
            w_rem  = r_ang[AngleBits-3:0];
        end else begin
            w_quad = w_sang[AngleBits-1:AngleBits-2];
            w_rem  = w_sang[AngleBits-3:0];
        end
        w_qneg = (w_quad == 2'd1) || (w_quad == 2'd2);
        if (w_quad == 2'd0 || w_quad == 2'd2) begin
            w_rom_addr = (AngleBits-1)'(w_rem);
        end else begin
            w_rom_addr = (AngleBits-1)'(Quarter) - (AngleBits-1)'(w_rem);
        end
    end

    always_comb begin
        if (r_state == S_XF) begin
            w_rel = 35'(r_sy) + 35'(r_accy >>> 15) - 35'(r_origin_y);
        end else begin
            w_rel = 35'(r_sx) + 35'(r_accx >>> 15) - 35'(r_origin_x);
        end
    end

    assign w_cell_prod = 58'(r_plo) + (58'(w_p) << 24);
    assign w_out = (r_negx && r_cx != 26'd0) || (r_negy && r_cy != 26'd0)
                   || (r_cx >= 26'(r_gw)) || (r_cy >= 26'(r_gh));
    assign w_idx = 19'(w_p[17:0]) + 19'(r_cx[8:0]);
    assign w_raddr = AddrW'(w_idx);
    assign w_dmag = w_p[35:0];

    always_comb begin
        case (r_state)
            S_DX: begin
                w_mul_a = MulW'(w_step);
                w_mul_b = MulW'(r_cmag);
            end
            S_DY: begin
                w_mul_a = MulW'(w_step);
                w_mul_b = MulW'(w_rom);
            end
            S_XL, S_YL: begin
                w_mul_a = r_mag[23:0];
                w_mul_b = MulW'(r_cpm);
            end
            S_XH, S_YH: begin
                w_mul_a = MulW'(r_mag[34:24]);
                w_mul_b = MulW'(r_cpm);
            end
            S_BND: begin
                w_mul_a = MulW'(r_cy[8:0]);
                w_mul_b = MulW'(r_gw);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start && i_req_type == REQ_CAST) begin
                    n_state = S_TC;
                end
            end
            S_TC:  n_state = S_TS;
            S_TS:  n_state = S_DX;
            S_DX:  n_state = S_DY;
            S_DY:  n_state = S_DW;
            S_DW:  n_state = S_CHK;
            S_CHK: n_state = (25'(r_max) <= r_range) ? S_IDLE : S_XL;
            S_XL:  n_state = S_XH;
            S_XH:  n_state = S_XF;
            S_XF:  n_state = S_YL;
            S_YL:  n_state = S_YH;
            S_YH:  n_state = S_YF;
            S_YF:  n_state = S_BND;
            S_BND: n_state = w_out ? S_IDLE : S_IDX;
            S_IDX: n_state = (32'(w_idx) >= 32'(Cells)) ? S_IDLE : S_RD;
            S_RD:  n_state = w_occ ? S_IDLE : S_CHK;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= 1'b0;
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_cell_size <= CellSizeRst;
            r_cpm       <= CellsPerMeterRst;
            r_gw        <= GridSideRst;
            r_gh        <= GridSideRst;
        end else begin
            r_state <= n_state;
            r_valid <= busy && (n_state == S_IDLE);
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_ORIGIN_X:        r_origin_x  <= i_cfg_wdata;
                    CFG_ORIGIN_Y:        r_origin_y  <= i_cfg_wdata;
                    CFG_CELL_SIZE:       r_cell_size <= i_cfg_wdata[20:0];
                    CFG_CELLS_PER_METER: r_cpm       <= i_cfg_wdata[22:0];
                    CFG_GRID_WIDTH:      r_gw        <= i_cfg_wdata[8:0];
                    CFG_GRID_HEIGHT:     r_gh        <= i_cfg_wdata[8:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_sx    <= i_pose_x;
                r_sy    <= i_pose_y;
                r_ang   <= AngleBits'(w_ang_sum);
                r_max   <= i_max_range;
                r_range <= '0;
                r_accx  <= '0;
                r_accy  <= '0;
            end
            S_TC: r_cneg <= w_qneg;
            S_TS: begin
                r_cmag <= w_rom;
                r_sneg <= w_qneg;
            end
            S_DY: r_dx <= r_cneg ? -$signed(w_dmag) : $signed(w_dmag);
            S_DW: r_dy <= r_sneg ? -$signed(w_dmag) : $signed(w_dmag);
            S_CHK: begin
                r_mag       <= w_rel[34] ? 35'(-w_rel) : 35'(w_rel);
                r_neg       <= w_rel[34];
                r_out_range <= r_max;
                r_hit       <= 1'b0;
            end
            S_XH, S_YH: r_plo <= w_p;
            S_XF: begin
                r_cx   <= w_cell_prod[57:32];
                r_negx <= r_neg;
                r_mag  <= w_rel[34] ? 35'(-w_rel) : 35'(w_rel);
                r_neg  <= w_rel[34];
            end
            S_YF: begin
                r_cy   <= w_cell_prod[57:32];
                r_negy <= r_neg;
            end
            S_BND, S_IDX: begin
                r_out_range <= r_range[23:0];
                r_hit       <= 1'b1;
            end
            S_RD: begin
                r_out_range <= r_range[23:0];
                r_hit       <= 1'b1;
                if (!w_occ) begin
                    r_range <= r_range + 25'(w_step);
                    r_accx  <= r_accx + 42'(r_dx);
                    r_accy  <= r_accy + 42'(r_dy);
                end
            end
            default: ;
        endcase
    end

    assign o_result_valid = r_valid;
    assign o_range        = r_out_range;
    assign o_hit_found    = r_hit;
endmodule
